/* design/dnsrw_pkg.sv */
package dnsrw_pkg;

   localparam int BUFFER_BYTES = 512;
   localparam int ADDR_W = $clog2(BUFFER_BYTES);
   localparam int CNT_W = $clog2(BUFFER_BYTES + 1);
   localparam int LBL_W = $clog2(BUFFER_BYTES + 256);
   localparam int SUM_W = LBL_W + 1;
   localparam int LEN_W = 10;
   localparam int CSR_IDX_W = 1;
   localparam int CSR_DATA_W = 32;
   localparam int HDR_LEN = 12;
   localparam int ANSWER_LEN = 16;
   localparam int TYPE_CLASS_LEN = 4;
   localparam int RSP_DATA_W = 24;

   localparam logic [CSR_IDX_W-1:0] CSR_ANSWER_ADDRESS = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_TTL_SECONDS = CSR_IDX_W'(1);

   localparam logic [7:0] ANS_PTR_HI = 8'hC0;
   localparam logic [7:0] ANS_PTR_LO = 8'h0C;
   localparam logic [7:0] FLAGS_HI = 8'h81;
   localparam logic [7:0] FLAGS_LO = 8'h80;
   localparam logic [7:0] TTL_RESET = 8'd60;

   typedef enum logic [2:0] {
      STAT_TAKEN   = 3'd0,
      STAT_READY   = 3'd1,
      STAT_DROPPED = 3'd2,
      STAT_BYTE    = 3'd3,
      STAT_NONE    = 3'd4
   } status_type;

   typedef enum logic {
      CMD_PUSH = 1'b0,
      CMD_READ = 1'b1
   } command_type;

   typedef struct packed {
      logic push;
      logic form_read;
   } dp_cmd_type;

   function automatic logic [7:0] answer_byte(input logic [3:0] offset,
                                              input logic [31:0] addr,
                                              input logic [7:0] ttl);
      logic [7:0] b;
      case (offset)
         4'd0:    b = ANS_PTR_HI;
         4'd1:    b = ANS_PTR_LO;
         4'd3:    b = 8'h01;
         4'd5:    b = 8'h01;
         4'd9:    b = ttl;
         4'd11:   b = 8'h04;
         4'd12:   b = addr[31:24];
         4'd13:   b = addr[23:16];
         4'd14:   b = addr[15:8];
         4'd15:   b = addr[7:0];
         default: b = 8'h00;
      endcase
      return b;
   endfunction

endpackage

/* design/dnsrw_ram.sv */
module dnsrw_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 512
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

/* design/dnsrw_ctl.sv */
module dnsrw_ctl
   import dnsrw_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  command_type req_cmd,
   output logic        req_tready,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output dp_cmd_type  cmd
);

   typedef enum logic [2:0] {
      S_IDLE  = 3'b001,
      S_FETCH = 3'b010,
      S_RESP  = 3'b100
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      req_tready = 1'b0;
      rsp_tvalid = 1'b0;
      cmd = '0;
      unique case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               if (req_cmd == CMD_PUSH) begin
                  cmd.push = 1'b1;
                  state_in = S_RESP;
               end else begin
                  state_in = S_FETCH;
               end
            end
         end
         S_FETCH: begin
            cmd.form_read = 1'b1;
            state_in = S_RESP;
         end
         S_RESP: begin
            rsp_tvalid = 1'b1;
            if (rsp_tready) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   a_form_then_resp: assert property (@(posedge clock) disable iff (reset)
      cmd.form_read |=> rsp_tvalid) else $error("read result not presented");

   a_push_then_resp: assert property (@(posedge clock) disable iff (reset)
      cmd.push |=> rsp_tvalid) else $error("push result not presented");

   a_state_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot(state_ff)) else $error("state not one-hot");

endmodule

/* design/dnsrw_dp.sv */
module dnsrw_dp
   import dnsrw_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  dp_cmd_type            cmd,
   input  logic [7:0]            data_byte,
   input  logic                  frame_last,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output status_type            status,
   output logic [7:0]            reply_byte,
   output logic                  reply_last,
   output logic [LEN_W-1:0]      reply_length
);

   typedef enum logic [1:0] {
      PH_WALK = 2'd0,
      PH_DONE = 2'd1,
      PH_BAD  = 2'd2
   } phase_type;

   logic [CNT_W-1:0]  byte_count_ff, byte_count_in;
   logic [LBL_W-1:0]  next_label_ff, next_label_in;
   logic [CNT_W-1:0]  question_end_ff, question_end_in;
   phase_type         phase_ff, phase_in;
   logic [CNT_W-1:0]  reply_total_ff, reply_total_in;
   logic [CNT_W-1:0]  read_index_ff, read_index_in;
   logic [CNT_W-1:0]  reply_qend_ff, reply_qend_in;
   logic [7:0]        flags_hi_ff, flags_hi_in;
   logic [7:0]        qd_hi_ff, qd_hi_in;
   logic [7:0]        qd_lo_ff, qd_lo_in;
   logic [31:0]       cfg_addr_ff;
   logic [7:0]        cfg_ttl_ff;
   logic [31:0]       ans_addr_ff, ans_addr_in;
   logic [7:0]        ans_ttl_ff, ans_ttl_in;
   status_type        status_ff, status_in;
   logic [7:0]        byte_ff, byte_in;
   logic              last_ff, last_in;
   logic [LEN_W-1:0]  len_ff, len_in;

   logic [7:0]        ram_rdata;
   logic              room;
   logic [CNT_W-1:0]  pos;
   logic [CNT_W-1:0]  cnt_new;
   logic [CNT_W-1:0]  qe_new;
   phase_type         ph_new;
   logic [LBL_W-1:0]  lbl_new;
   logic [SUM_W-1:0]  qend_sum;
   logic [SUM_W-1:0]  len_sum;
   logic              verdict_ok;
   logic [CNT_W-1:0]  idx_next;
   logic [CNT_W-1:0]  ans_offset;
   logic [7:0]        sel_byte;

   assign pos = byte_count_ff;
   assign room = byte_count_ff < CNT_W'(BUFFER_BYTES);

   dnsrw_ram #(
      .WIDTH(8),
      .DEPTH(BUFFER_BYTES)
   ) u_store (
      .clock(clock),
      .we   (cmd.push && room),
      .waddr(pos[ADDR_W-1:0]),
      .wdata(data_byte),
      .raddr(read_index_ff[ADDR_W-1:0]),
      .rdata(ram_rdata)
   );

   // name walk on the incoming byte
   always_comb begin
      cnt_new = byte_count_ff;
      qe_new = question_end_ff;
      ph_new = phase_ff;
      lbl_new = next_label_ff;
      flags_hi_in = flags_hi_ff;
      qd_hi_in = qd_hi_ff;
      qd_lo_in = qd_lo_ff;
      if (cmd.push && room) begin
         cnt_new = pos + CNT_W'(1);
         if (pos == CNT_W'(2)) begin
            flags_hi_in = data_byte;
         end
         if (pos == CNT_W'(4)) begin
            qd_hi_in = data_byte;
         end
         if (pos == CNT_W'(5)) begin
            qd_lo_in = data_byte;
         end
         if (phase_ff == PH_WALK && LBL_W'(pos) == next_label_ff) begin
            if (data_byte == 8'h00) begin
               qe_new = pos + CNT_W'(1);
               ph_new = PH_DONE;
            end else if (data_byte[7:6] != 2'b00) begin
               ph_new = PH_BAD;
            end else begin
               lbl_new = LBL_W'(pos) + LBL_W'(1) + LBL_W'(data_byte);
            end
         end
      end
   end

   assign qend_sum = SUM_W'(qe_new) + SUM_W'(TYPE_CLASS_LEN);
   assign len_sum = qend_sum + SUM_W'(ANSWER_LEN);

   always_comb begin
      verdict_ok = 1'b1;
      if (cnt_new < CNT_W'(HDR_LEN)) verdict_ok = 1'b0;
      if (flags_hi_in[7]) verdict_ok = 1'b0;
      if (flags_hi_in[6:3] != 4'h0) verdict_ok = 1'b0;
      if ({qd_hi_in, qd_lo_in} != 16'h0001) verdict_ok = 1'b0;
      if (ph_new != PH_DONE) verdict_ok = 1'b0;
      if (qend_sum > SUM_W'(cnt_new)) verdict_ok = 1'b0;
      if (len_sum > SUM_W'(BUFFER_BYTES)) verdict_ok = 1'b0;
   end

   // reply byte with the header rewrite and the answer record laid over the store
   assign ans_offset = read_index_ff - reply_qend_ff;
   assign idx_next = read_index_ff + CNT_W'(1);

   always_comb begin
      case (read_index_ff) inside
         CNT_W'(2):                      sel_byte = FLAGS_HI;
         CNT_W'(3):                      sel_byte = FLAGS_LO;
         CNT_W'(7):                      sel_byte = 8'h01;
         CNT_W'(6), [CNT_W'(8):CNT_W'(11)]: sel_byte = 8'h00;
         default: begin
            if (read_index_ff >= reply_qend_ff) begin
               sel_byte = answer_byte(ans_offset[3:0], ans_addr_ff, ans_ttl_ff);
            end else begin
               sel_byte = ram_rdata;
            end
         end
      endcase
   end

   always_comb begin
      byte_count_in = byte_count_ff;
      next_label_in = next_label_ff;
      question_end_in = question_end_ff;
      phase_in = phase_ff;
      reply_total_in = reply_total_ff;
      read_index_in = read_index_ff;
      reply_qend_in = reply_qend_ff;
      ans_addr_in = ans_addr_ff;
      ans_ttl_in = ans_ttl_ff;
      status_in = status_ff;
      byte_in = byte_ff;
      last_in = last_ff;
      len_in = len_ff;
      if (cmd.push) begin
         reply_total_in = '0;
         read_index_in = '0;
         byte_in = 8'h00;
         last_in = 1'b0;
         len_in = '0;
         status_in = STAT_TAKEN;
         byte_count_in = cnt_new;
         next_label_in = lbl_new;
         question_end_in = qe_new;
         phase_in = ph_new;
         if (frame_last) begin
            byte_count_in = '0;
            next_label_in = LBL_W'(HDR_LEN);
            question_end_in = '0;
            phase_in = PH_WALK;
            if (verdict_ok) begin
               status_in = STAT_READY;
               reply_total_in = len_sum[CNT_W-1:0];
               reply_qend_in = qend_sum[CNT_W-1:0];
               ans_addr_in = cfg_addr_ff;
               ans_ttl_in = cfg_ttl_ff;
               len_in = len_sum[LEN_W-1:0];
            end else begin
               status_in = STAT_DROPPED;
            end
         end
      end else if (cmd.form_read) begin
         byte_in = 8'h00;
         last_in = 1'b0;
         len_in = '0;
         if (reply_total_ff == '0 || read_index_ff >= reply_total_ff) begin
            status_in = STAT_NONE;
         end else begin
            status_in = STAT_BYTE;
            byte_in = sel_byte;
            read_index_in = idx_next;
            if (idx_next == reply_total_ff) begin
               last_in = 1'b1;
               reply_total_in = '0;
               read_index_in = '0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_count_ff <= '0;
         next_label_ff <= LBL_W'(HDR_LEN);
         question_end_ff <= '0;
         phase_ff <= PH_WALK;
         reply_total_ff <= '0;
         read_index_ff <= '0;
         cfg_addr_ff <= '0;
         cfg_ttl_ff <= TTL_RESET;
      end else begin
         byte_count_ff <= byte_count_in;
         next_label_ff <= next_label_in;
         question_end_ff <= question_end_in;
         phase_ff <= phase_in;
         reply_total_ff <= reply_total_in;
         read_index_ff <= read_index_in;
         if (csr_we && csr_index == CSR_ANSWER_ADDRESS) begin
            cfg_addr_ff <= csr_wdata;
         end
         if (csr_we && csr_index == CSR_TTL_SECONDS) begin
            cfg_ttl_ff <= csr_wdata[7:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      flags_hi_ff <= flags_hi_in;
      qd_hi_ff <= qd_hi_in;
      qd_lo_ff <= qd_lo_in;
      reply_qend_ff <= reply_qend_in;
      ans_addr_ff <= ans_addr_in;
      ans_ttl_ff <= ans_ttl_in;
      status_ff <= status_in;
      byte_ff <= byte_in;
      last_ff <= last_in;
      len_ff <= len_in;
   end

   assign status = status_ff;
   assign reply_byte = byte_ff;
   assign reply_last = last_ff;
   assign reply_length = len_ff;

   a_index_in_reply: assert property (@(posedge clock) disable iff (reset)
      reply_total_ff != '0 |-> read_index_ff < reply_total_ff)
      else $error("read index past reply");

   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      byte_count_ff <= CNT_W'(BUFFER_BYTES)) else $error("byte count past buffer");

   a_push_cancels: assert property (@(posedge clock) disable iff (reset)
      cmd.push |=> read_index_ff == '0 &&
         (reply_total_ff == '0 || status_ff == STAT_READY))
      else $error("request did not cancel reply");

endmodule

/* design/dns_query_reply_rewriter.sv */
// DNS query responder: request bytes enter on req_ with tuser 0 (push, tlast on
// the final datagram byte) or tuser 1 (read the next reply byte). Every request
// gets exactly one response. A push's response is presented in the cycle after
// acceptance (the name walk and verdict are worked out in the accept cycle); a
// read's response follows the fetch state, which covers the registered read port
// of the packet store. One request is in flight at a time, and the next is taken
// in the cycle after the response has been taken. The packet store needs no
// clearing after reset.
module dns_query_reply_rewriter
   import dnsrw_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [7:0]            req_tdata,   // data_byte
   input  logic                  req_tuser,   // command
   input  logic                  req_tlast,   // frame_last
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // reply_byte, reply_length, zero fill
   output logic [2:0]            rsp_tuser,   // status
   output logic                  rsp_tlast,   // reply_last
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   dp_cmd_type       cmd;
   status_type       status;
   logic [7:0]       reply_byte;
   logic [LEN_W-1:0] reply_length;

   dnsrw_ctl u_ctl (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_cmd   (command_type'(req_tuser)),
      .req_tready(req_tready),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .cmd       (cmd)
   );

   dnsrw_dp u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .data_byte   (req_tdata),
      .frame_last  (req_tlast),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .status      (status),
      .reply_byte  (reply_byte),
      .reply_last  (rsp_tlast),
      .reply_length(reply_length)
   );

   assign rsp_tuser = status;
   assign rsp_tdata = {(RSP_DATA_W - LEN_W - 8)'(0), reply_length, reply_byte};

endmodule
